/* rtl/dfs_maze_carver_defines.svh */
// assertion macros used by the maze carver datapath
`ifndef DFS_MAZE_CARVER_DEFINES_SVH
`define DFS_MAZE_CARVER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define DFS_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dfs assertion failed");

// next-cycle implication, checked out of reset
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dfs assertion failed");

`else

`define DFS_ASSERT(lbl, clk, rst_n, ante, cons)
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/dfs_pkg.sv */
// shared types, constants and the direction-order table of the maze carver
`default_nettype none

package dfs_pkg;

	localparam int CODE_W = 5;
	localparam int CFG_W  = 7;
	localparam int FROM_W = 6;
	localparam int DIR_W  = 2;
	localparam int SIZE_W = 9;
	localparam int POS_W  = 3;

	localparam logic [CODE_W-1:0] CODE_COUNT = 5'd24;
	localparam logic [POS_W-1:0]  POS_END    = 3'd4;
	localparam logic [CFG_W-1:0]  CFG_RESET  = 7'd64;

	localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
	localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
	localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

	localparam logic CFG_LEVEL_WIDTH  = 1'b0;
	localparam logic CFG_LEVEL_HEIGHT = 1'b1;

	typedef struct packed {
		logic start;
		logic resume;
		logic advance;
		logic pop;
		logic load_top;
		logic push;
		logic finish;
		logic clear_step;
	} dfs_cmd_t;

	typedef struct packed {
		logic depth_zero;
		logic depth_one;
		logic pos_done;
		logic nbr_ok;
		logic visited;
		logic out_free;
		logic clear_last;
	} dfs_status_t;

	// direction at position pos of lexicographic permutation code of N,S,E,W
	function automatic logic [DIR_W-1:0] dir_at(input logic [CODE_W-1:0] code,
		input logic [1:0] pos);
		logic [4*DIR_W-1:0] perm;
		logic [DIR_W-1:0]   dir;
		case (code)
			5'd0:    perm = {DIR_NORTH, DIR_SOUTH, DIR_EAST, DIR_WEST};
			5'd1:    perm = {DIR_NORTH, DIR_SOUTH, DIR_WEST, DIR_EAST};
			5'd2:    perm = {DIR_NORTH, DIR_EAST, DIR_SOUTH, DIR_WEST};
			5'd3:    perm = {DIR_NORTH, DIR_EAST, DIR_WEST, DIR_SOUTH};
			5'd4:    perm = {DIR_NORTH, DIR_WEST, DIR_SOUTH, DIR_EAST};
			5'd5:    perm = {DIR_NORTH, DIR_WEST, DIR_EAST, DIR_SOUTH};
			5'd6:    perm = {DIR_SOUTH, DIR_NORTH, DIR_EAST, DIR_WEST};
			5'd7:    perm = {DIR_SOUTH, DIR_NORTH, DIR_WEST, DIR_EAST};
			5'd8:    perm = {DIR_SOUTH, DIR_EAST, DIR_NORTH, DIR_WEST};
			5'd9:    perm = {DIR_SOUTH, DIR_EAST, DIR_WEST, DIR_NORTH};
			5'd10:   perm = {DIR_SOUTH, DIR_WEST, DIR_NORTH, DIR_EAST};
			5'd11:   perm = {DIR_SOUTH, DIR_WEST, DIR_EAST, DIR_NORTH};
			5'd12:   perm = {DIR_EAST, DIR_NORTH, DIR_SOUTH, DIR_WEST};
			5'd13:   perm = {DIR_EAST, DIR_NORTH, DIR_WEST, DIR_SOUTH};
			5'd14:   perm = {DIR_EAST, DIR_SOUTH, DIR_NORTH, DIR_WEST};
			5'd15:   perm = {DIR_EAST, DIR_SOUTH, DIR_WEST, DIR_NORTH};
			5'd16:   perm = {DIR_EAST, DIR_WEST, DIR_NORTH, DIR_SOUTH};
			5'd17:   perm = {DIR_EAST, DIR_WEST, DIR_SOUTH, DIR_NORTH};
			5'd18:   perm = {DIR_WEST, DIR_NORTH, DIR_SOUTH, DIR_EAST};
			5'd19:   perm = {DIR_WEST, DIR_NORTH, DIR_EAST, DIR_SOUTH};
			5'd20:   perm = {DIR_WEST, DIR_SOUTH, DIR_NORTH, DIR_EAST};
			5'd21:   perm = {DIR_WEST, DIR_SOUTH, DIR_EAST, DIR_NORTH};
			5'd22:   perm = {DIR_WEST, DIR_EAST, DIR_NORTH, DIR_SOUTH};
			5'd23:   perm = {DIR_WEST, DIR_EAST, DIR_SOUTH, DIR_NORTH};
			default: perm = '0;
		endcase
		case (pos)
			2'd0:    dir = perm[7:6];
			2'd1:    dir = perm[5:4];
			2'd2:    dir = perm[3:2];
			default: dir = perm[1:0];
		endcase
		return dir;
	endfunction

endpackage

`default_nettype wire

/* rtl/dfs_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module dfs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/dfs_ctrl.sv */
// sequencer of the maze carver: accept, scan, pop, visited check, clear sweep
`default_nettype none

module dfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dfs_pkg::dfs_status_t status,
	output dfs_pkg::dfs_cmd_t    cmd
);
	import dfs_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (status.depth_zero) begin
						cmd.start = 1'b1;
					end else begin
						cmd.resume = 1'b1;
					end
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.pos_done) begin
					if (status.depth_one) begin
						// last frame used up: report finished, then wipe the map
						if (status.out_free) begin
							cmd.finish = 1'b1;
							state_d    = ST_CLEAR;
						end
					end else begin
						cmd.pop = 1'b1;
						state_d = ST_LOAD;
					end
				end else begin
					cmd.advance = 1'b1;
					if (status.nbr_ok) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_top = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_CHECK: begin
				if (status.visited) begin
					state_d = ST_SCAN;
				end else if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/dfs_datapath.sv */
// datapath of the maze carver: top frame, walk stack, visited map, result register
`default_nettype none
`include "dfs_maze_carver_defines.svh"

module dfs_datapath #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfs_pkg::dfs_cmd_t             cmd,
	output dfs_pkg::dfs_status_t          status,
	input  logic [dfs_pkg::CFG_W-1:0]     level_width,
	input  logic [dfs_pkg::CFG_W-1:0]     level_height,
	input  logic [dfs_pkg::CODE_W-1:0]    order_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dfs_pkg::FROM_W-1:0]    from_x,
	output logic [dfs_pkg::FROM_W-1:0]    from_y,
	output logic [dfs_pkg::DIR_W-1:0]     carve_dir,
	output logic                          finished
);
	import dfs_pkg::*;

	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int XW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int YW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int DW      = $clog2(CELL_COUNT + 1);
	localparam int FRAME_W = XW + YW + CODE_W + POS_W;

	// top frame of the walk, kept out of the stack ram
	logic [XW-1:0]     top_x_q;
	logic [YW-1:0]     top_y_q;
	logic [CODE_W-1:0] top_code_q;
	logic [POS_W-1:0]  top_pos_q;
	logic [DW-1:0]     depth_q;

	logic [XW-1:0]     nbr_x_q;
	logic [YW-1:0]     nbr_y_q;
	logic [DIR_W-1:0]  nbr_dir_q;
	logic [AW-1:0]     clr_cnt_q;

	logic              out_valid_q;
	logic [FROM_W-1:0] from_x_q;
	logic [FROM_W-1:0] from_y_q;
	logic [DIR_W-1:0]  carve_dir_q;
	logic              finished_q;

	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [CODE_W-1:0] code_red;
	logic [DIR_W-1:0]  dir_cur;
	logic [XW:0]       nx;
	logic [YW:0]       ny;
	logic              border_ok;
	logic              nbr_ok;
	logic              out_free;
	logic              clear_last;
	logic [AW-1:0]     nbr_addr;
	logic [AW-1:0]     push_addr;

	logic              vis_wr_en;
	logic [AW-1:0]     vis_wr_addr;
	logic              vis_wr_data;
	logic              vis_rd_data;
	logic [FRAME_W-1:0] stk_wr_data;
	logic [FRAME_W-1:0] stk_rd_data;

	// sizes clamped to 1..max
	always_comb begin
		if (level_width == '0) begin
			w_eff = SIZE_W'(1);
		end else if (SIZE_W'(level_width) > SIZE_W'(MAX_COLUMNS)) begin
			w_eff = SIZE_W'(MAX_COLUMNS);
		end else begin
			w_eff = SIZE_W'(level_width);
		end
		if (level_height == '0) begin
			h_eff = SIZE_W'(1);
		end else if (SIZE_W'(level_height) > SIZE_W'(MAX_ROWS)) begin
			h_eff = SIZE_W'(MAX_ROWS);
		end else begin
			h_eff = SIZE_W'(level_height);
		end
	end

	// codes 24..31 fold onto 0..7
	assign code_red = (order_code >= CODE_COUNT) ? order_code - CODE_COUNT : order_code;

	assign dir_cur = dir_at(top_code_q, top_pos_q[1:0]);

	always_comb begin
		nx        = {1'b0, top_x_q};
		ny        = {1'b0, top_y_q};
		border_ok = 1'b1;
		case (dir_cur)
			DIR_NORTH: begin
				if (top_y_q == '0) begin
					border_ok = 1'b0;
				end else begin
					ny = ny - (YW+1)'(1);
				end
			end
			DIR_SOUTH: ny = ny + (YW+1)'(1);
			DIR_EAST:  nx = nx + (XW+1)'(1);
			DIR_WEST: begin
				if (top_x_q == '0) begin
					border_ok = 1'b0;
				end else begin
					nx = nx - (XW+1)'(1);
				end
			end
			default: border_ok = 1'b0;
		endcase
	end

	assign nbr_ok = border_ok && (SIZE_W'(nx) < w_eff) && (SIZE_W'(ny) < h_eff);

	assign nbr_addr  = AW'(AW'(ny[YW-1:0]) * AW'(MAX_COLUMNS) + AW'(nx[XW-1:0]));
	assign push_addr = AW'(AW'(nbr_y_q) * AW'(MAX_COLUMNS) + AW'(nbr_x_q));

	assign out_free   = !out_valid_q || !out_stall;
	assign clear_last = (clr_cnt_q == AW'(CELL_COUNT - 1));

	// visited map: one write port shared by run start, push and clear sweep
	assign vis_wr_en   = cmd.start || cmd.push || cmd.clear_step;
	assign vis_wr_data = !cmd.clear_step;
	always_comb begin
		if (cmd.clear_step) begin
			vis_wr_addr = clr_cnt_q;
		end else if (cmd.start) begin
			vis_wr_addr = '0;
		end else begin
			vis_wr_addr = push_addr;
		end
	end

	dfs_ram #(
		.WIDTH (1),
		.DEPTH (CELL_COUNT)
	) u_visited (
		.clk     (clk),
		.wr_en   (vis_wr_en),
		.wr_addr (vis_wr_addr),
		.wr_data (vis_wr_data),
		.rd_en   (cmd.advance),
		.rd_addr (nbr_addr),
		.rd_data (vis_rd_data)
	);

	// stack holds every frame below the top one
	assign stk_wr_data = {top_x_q, top_y_q, top_code_q, top_pos_q};

	dfs_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (CELL_COUNT)
	) u_stack (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (AW'(depth_q - DW'(1))),
		.wr_data (stk_wr_data),
		.rd_en   (cmd.pop),
		.rd_addr (AW'(depth_q - DW'(2))),
		.rd_data (stk_rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			top_x_q    <= '0;
			top_y_q    <= '0;
			top_code_q <= code_red;
			top_pos_q  <= '0;
		end else if (cmd.resume) begin
			top_code_q <= code_red;
			top_pos_q  <= '0;
		end else if (cmd.advance) begin
			top_pos_q <= top_pos_q + POS_W'(1);
		end else if (cmd.load_top) begin
			{top_x_q, top_y_q, top_code_q, top_pos_q} <= stk_rd_data;
		end else if (cmd.push) begin
			top_x_q    <= nbr_x_q;
			top_y_q    <= nbr_y_q;
			top_code_q <= '0;
			top_pos_q  <= '0;
		end
		if (cmd.advance) begin
			nbr_x_q   <= nx[XW-1:0];
			nbr_y_q   <= ny[YW-1:0];
			nbr_dir_q <= dir_cur;
		end
		if (cmd.push) begin
			from_x_q    <= FROM_W'(top_x_q);
			from_y_q    <= FROM_W'(top_y_q);
			carve_dir_q <= nbr_dir_q;
			finished_q  <= 1'b0;
		end else if (cmd.finish) begin
			from_x_q    <= '0;
			from_y_q    <= '0;
			carve_dir_q <= '0;
			finished_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				depth_q <= DW'(1);
			end else if (cmd.push) begin
				depth_q <= depth_q + DW'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - DW'(1);
			end else if (cmd.finish) begin
				depth_q <= '0;
			end
			if (cmd.clear_step) begin
				clr_cnt_q <= clear_last ? '0 : clr_cnt_q + AW'(1);
			end
			if (cmd.push || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status            = '0;
		status.depth_zero = (depth_q == '0);
		status.depth_one  = (depth_q == DW'(1));
		status.pos_done   = (top_pos_q >= POS_END);
		status.nbr_ok     = nbr_ok;
		status.visited    = vis_rd_data;
		status.out_free   = out_free;
		status.clear_last = clear_last;
	end

	assign out_valid = out_valid_q;
	assign from_x    = from_x_q;
	assign from_y    = from_y_q;
	assign carve_dir = carve_dir_q;
	assign finished  = finished_q;

	`DFS_ASSERT(a_push_in_range, clk, arst_n, cmd.push, (SIZE_W'(nbr_x_q) < w_eff) && (SIZE_W'(nbr_y_q) < h_eff))
	`DFS_ASSERT(a_no_overwrite, clk, arst_n, cmd.push || cmd.finish, !(out_valid_q && out_stall))
	`DFS_ASSERT(a_walk_nonempty, clk, arst_n, cmd.advance || cmd.pop || cmd.push, depth_q != '0)
	`DFS_ASSERT_NEXT(a_sweep_starts_at_zero, clk, arst_n, cmd.finish, clr_cnt_q == '0)

endmodule

`default_nettype wire

/* rtl/dfs_maze_carver.sv */
// top level of the depth-first maze carver: config registers, sequencer, datapath
//
//  channel  dir  handshake             payload
//  in       in   in_valid / in_stall   order_code
//  out      out  out_valid / out_stall from_x, from_y, carve_dir, finished
//  cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// an item is accepted, then each direction is tried in the scan state; one that
//   reaches an in-range cell also reads the visited map (check state), and a
//   popped frame is read from the stack ram and loaded into the top frame (load state)
// a finished item is followed by a sweep clearing all MAX_COLUMNS*MAX_ROWS cells of
//   the visited map, one cell per cycle; no item is taken during it
// after reset the same sweep runs before the first item is accepted
// a stalled result waits in the output register; the next item is accepted meanwhile
`default_nettype none

module dfs_maze_carver #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// item input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [dfs_pkg::CODE_W-1:0] order_code,
	// result output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [dfs_pkg::FROM_W-1:0] from_x,
	output logic [dfs_pkg::FROM_W-1:0] from_y,
	output logic [dfs_pkg::DIR_W-1:0]  carve_dir,
	output logic                       finished,
	// register writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [dfs_pkg::CFG_W-1:0]  cfg_data
);
	import dfs_pkg::*;

	logic [CFG_W-1:0] level_width_q;
	logic [CFG_W-1:0] level_height_q;
	dfs_cmd_t         cmd;
	dfs_status_t      status;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_width_q  <= CFG_RESET;
			level_height_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEVEL_WIDTH:  level_width_q  <= cfg_data;
				CFG_LEVEL_HEIGHT: level_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: decides each cycle what the datapath does
	dfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// top frame, stack ram, visited ram and result register
	dfs_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.level_width  (level_width_q),
		.level_height (level_height_q),
		.order_code   (order_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.from_x       (from_x),
		.from_y       (from_y),
		.carve_dir    (carve_dir),
		.finished     (finished)
	);

endmodule

`default_nettype wire
